/* rtl/fbk_pkg.sv */
// Shared constants and types for the FIR filter bank.
`timescale 1ns / 1ps
package fbk_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int NUM_FILTERS = 4;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 40;
  localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int FILT_W   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int CADDR_W  = FILT_W + TAP_W;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int PADDR_W  = 3;
  localparam int REG_W    = 7;

  localparam logic [0:0] REG_TAP_COUNT = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic               en;
    logic [CADDR_W-1:0] addr;
    sample_t            data;
  } coef_wr_t;

  typedef struct packed {
    logic               active;
    logic [CADDR_W-1:0] addr;
    sample_t            sample;
  } mac_rd_t;

endpackage

/* rtl/fbk_cell.sv */
// One delay line cell: shifts in from the lower neighbor, rotates in from the upper one.
`timescale 1ns / 1ps
module fbk_cell (
  input  logic               clk,
  input  logic               rst,
  input  fbk_pkg::cell_ctl_t ctl,
  input  fbk_pkg::sample_t   from_lo,
  input  fbk_pkg::sample_t   from_hi,
  output fbk_pkg::sample_t   sample
);
  import fbk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctl.shift) begin
      sample <= from_lo;
    end else if (ctl.rotate) begin
      sample <= from_hi;
    end
  end

endmodule

/* rtl/fbk_mac.sv */
// Coefficient memory and multiply-accumulate unit.
`timescale 1ns / 1ps
module fbk_mac (
  input  logic              clk,
  input  logic              rst,
  input  fbk_pkg::coef_wr_t wr,
  input  fbk_pkg::mac_rd_t  rd,
  input  logic              acc_clear,
  output fbk_pkg::acc_t     acc
);
  import fbk_pkg::*;

  localparam int DEPTH = NUM_FILTERS * MAX_TAPS;

  sample_t                    mem [DEPTH];
  sample_t                    coef_q;
  sample_t                    samp_q;
  logic                       v1;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                       v2;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    coef_q <= mem[rd.addr];
    samp_q <= rd.sample;
    prod   <= coef_q * samp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= rd.active;
      v2 <= v1;
      if (acc_clear) begin
        acc <= '0;
      end else if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

/* rtl/fir_filter_bank.sv */
// Top level of the FIR filter bank: sample chain, sequencer, config port and output stage.
`timescale 1ns / 1ps
// A coefficient write or a warm-up sample is taken in ST_IDLE and starts no pass. A sample
// that produces outputs holds in_ready low until the last filter's result is loaded,
// including any time the output waits on out_ready: for each filter the delay line
// chain rotates once through all MAX_TAPS cells past a single multiply-accumulate
// unit, then drain states ST_DRAIN_A and ST_DRAIN_B and ST_EMIT to load the result.
// Outputs come filter 0 first; last_of_run marks the last filter's output.
module fir_filter_bank (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbk_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic signed [15:0]           sample_value,
  input  logic [1:0]                   coef_filter,
  input  logic [5:0]                   coef_tap,
  input  logic signed [15:0]           coef_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   filter_index,
  output logic signed [15:0]           filtered_value,
  output logic                         last_of_run,
  output logic                         saturated
);
  import fbk_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RUN     = 5'b00010,
    ST_DRAIN_A = 5'b00100,
    ST_DRAIN_B = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  state_t             state;
  logic [REG_W-1:0]   tap_count;
  logic [CNT_W-1:0]   warmup;
  logic [TAP_W-1:0]   tap;
  logic [FILT_W-1:0]  filt;

  logic [CNT_W-1:0]   taps_used;
  logic               warm;
  logic               in_take;
  logic               out_free;
  logic               last_filt;
  logic               last_tap;
  logic               cfg_wr;

  cell_ctl_t          ctl;
  coef_wr_t           wr;
  mac_rd_t            rd;
  logic               acc_clear;
  acc_t               acc;

  sample_t            chain [MAX_TAPS];

  logic signed [ACC_W:0] rounded;
  logic signed [ACC_W:0] quot;
  logic                  hi_sat;
  logic                  lo_sat;
  sample_t               result;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= REG_W'(1);
    end else if (cfg_wr) begin
      tap_count <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TAP_COUNT) begin
      prdata = 32'(tap_count);
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      taps_used = CNT_W'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps_used = CNT_W'(MAX_TAPS);
    end else begin
      taps_used = CNT_W'(tap_count);
    end
  end

  assign warm      = warmup >= (taps_used - CNT_W'(1));
  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_filt = (filt == FILT_W'(NUM_FILTERS - 1));
  assign last_tap  = (tap == TAP_W'(MAX_TAPS - 1));

  // Delay line chain
  assign ctl.shift  = in_take && !kind;
  assign ctl.rotate = (state == ST_RUN);

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    fbk_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .from_lo ((i == 0) ? sample_value : chain[(i == 0) ? 0 : i - 1]),
      .from_hi (chain[(i + 1) % MAX_TAPS]),
      .sample  (chain[i])
    );
  end

  // Coefficient store and MAC
  assign wr.en   = in_take && kind && (int'(coef_filter) < NUM_FILTERS)
                   && (int'(coef_tap) < MAX_TAPS);
  assign wr.addr = {FILT_W'(coef_filter), TAP_W'(coef_tap)};
  assign wr.data = coef_value;

  assign rd.active = (state == ST_RUN) && ({1'b0, tap} < taps_used);
  assign rd.addr   = {filt, tap};
  assign rd.sample = chain[0];

  assign acc_clear = (state == ST_IDLE) || ((state == ST_EMIT) && out_free);

  fbk_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd        (rd),
    .acc_clear (acc_clear),
    .acc       (acc)
  );

  // Round and saturate
  assign rounded = {acc[ACC_W-1], acc} + (ACC_W+1)'(16384);
  assign quot    = rounded >>> 15;
  assign hi_sat  = quot > (ACC_W+1)'(32767);
  assign lo_sat  = quot < -(ACC_W+1)'(32768);

  always_comb begin
    if (hi_sat) begin
      result = 16'sh7FFF;
    end else if (lo_sat) begin
      result = 16'sh8000;
    end else begin
      result = quot[SAMPLE_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      warmup <= '0;
      tap    <= '0;
      filt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take && !kind) begin
            if (warm) begin
              state <= ST_RUN;
              tap   <= '0;
              filt  <= '0;
            end else begin
              warmup <= warmup + CNT_W'(1);
            end
          end
        end
        ST_RUN: begin
          tap <= tap + TAP_W'(1);
          if (last_tap) begin
            state <= ST_DRAIN_A;
          end
        end
        ST_DRAIN_A: begin
          state <= ST_DRAIN_B;
        end
        ST_DRAIN_B: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_filt) begin
              state <= ST_IDLE;
            end else begin
              filt  <= filt + FILT_W'(1);
              tap   <= '0;
              state <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      filter_index   <= 2'(filt);
      filtered_value <= result;
      last_of_run    <= last_filt;
      saturated      <= hi_sat || lo_sat;
    end
  end

  // Checks
  a_warm_start: assert property (@(posedge clk) disable iff (rst)
    in_take && !kind && warm |=> (state == ST_RUN) && (filt == '0) && (tap == '0))
    else $error("warm sample did not start filter pass");

  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && last_tap |=> (state == ST_DRAIN_A) && $stable(filt))
    else $error("filter pass did not end after last tap");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_run == (32'(filter_index) == NUM_FILTERS - 1)))
    else $error("last_of_run does not match filter index");

endmodule
